// ===== rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg - text console glyph renderer shared definitions
// Geometry constants, field widths, codes and the glyph slot mapping.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Console geometry
  localparam int GLYPH_COUNT  = 192;
  localparam int GLYPH_HEIGHT = 10;
  localparam int LINE_PITCH   = 512;
  localparam int COLUMNS      = 96;
  localparam int ROWS         = 27;
  localparam int CELL_WIDTH   = 5;

  localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int ROW_STRIDE   = GLYPH_HEIGHT * LINE_PITCH;
  localparam int ROWCNT_W     = $clog2(GLYPH_HEIGHT + 1);

  // Field widths
  localparam int CODE_W  = 8;
  localparam int FADDR_W = 11;
  localparam int FDATA_W = 8;
  localparam int PIX_W   = 18;
  localparam int MASK_W  = 5;
  localparam int COLOR_W = 15;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 15'h7FFF;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Character codes and code bands
  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_HIGH_CTRL = 8'h80;
  localparam logic [CODE_W-1:0] CHAR_LATIN_LO  = 8'hA0;
  localparam logic [CODE_W-1:0] LATIN_OFFSET   = 8'h40;

  // Work handed from the cursor logic to the row sequencer
  typedef struct packed {
    logic                draw;
    logic                scroll;
    logic [STORE_AW-1:0] ram_base;
    logic [PIX_W-1:0]    pix_base;
  } cmd_t;

  // Character code to glyph slot; slot 0 draws nothing
  function automatic logic [CODE_W-1:0] glyph_slot(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] slot;
    if (code < CHAR_PRINT_LO) begin
      slot = '0;
    end else if (code < CHAR_HIGH_CTRL) begin
      slot = code - CHAR_PRINT_LO;
    end else if (code < CHAR_LATIN_LO) begin
      slot = '0;
    end else begin
      slot = code - LATIN_OFFSET;
    end
    return slot;
  endfunction

endpackage

// ===== rtl/tcgr_if.sv =====
// ----------------------------------------------------------------------------
// tcgr_if - text console glyph renderer channels
// Valid/ready channels for input items and rendered results.
// ----------------------------------------------------------------------------
interface tcgr_in_if import tcgr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [CODE_W-1:0]  char_code;
  logic [FADDR_W-1:0] font_address;
  logic [FDATA_W-1:0] font_data;

  modport source (output valid, op, char_code, font_address, font_data, input ready);
  modport sink   (input valid, op, char_code, font_address, font_data, output ready);
endinterface

interface tcgr_out_if import tcgr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_address;
  logic [MASK_W-1:0]  pixel_mask;
  logic [COLOR_W-1:0] color;
  logic               scroll;
  logic               last;

  modport source (output valid, pixel_address, pixel_mask, color, scroll, last,
                  input ready);
  modport sink   (input valid, pixel_address, pixel_mask, color, scroll, last,
                  output ready);
endinterface

// ===== rtl/text_console_glyph_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit - text console glyph renderer top level
// Character stream in, framebuffer glyph-row writes and scroll requests out.
// ----------------------------------------------------------------------------
// A put-character transaction that draws a glyph issues one font store read
// per glyph row, then a scroll beat if it also scrolls; one that scrolls
// without drawing issues only the scroll beat. The font store's single read
// port delivers one glyph row per cycle while the output path does not stall.
// The next input transaction is taken in the same cycle as the final beat
// is issued, while earlier results still drain through a two-deep output
// path. The font store has no reset and no clearing pass: load every glyph
// that will be printed before printing it.
module text_console_glyph_renderer_unit import tcgr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  tcgr_in_if.sink            in_ch,
  tcgr_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  logic [COLOR_W-1:0]  text_color_r;
  logic                in_acc, put, font_we, free, rd_en;
  logic [STORE_AW-1:0] rd_addr, wr_addr;
  logic [FDATA_W-1:0]  rd_data;
  cmd_t                cmd;

  // Input transaction decode
  always_comb begin
    in_ch.ready = free;
    in_acc      = in_ch.valid && free;
    put         = in_acc && (in_ch.op == OP_PUT);
    font_we     = in_acc && (in_ch.op == OP_LOAD) &&
                  (32'(in_ch.font_address) < STORE_DEPTH);
    wr_addr     = STORE_AW'(in_ch.font_address);
  end

  // Text colour register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= COLOR_RESET;
    end else if (cfg_we) begin
      text_color_r <= cfg_wdata;
    end
  end

  tcgr_ram #(
    .WIDTH (FDATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_font_store (
    .clk   (clk),
    .we    (font_we),
    .waddr (wr_addr),
    .wdata (in_ch.font_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tcgr_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .put       (put),
    .char_code (in_ch.char_code),
    .cmd       (cmd)
  );

  tcgr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (put),
    .cmd        (cmd),
    .text_color (text_color_r),
    .free       (free),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/tcgr_ram.sv =====
// ----------------------------------------------------------------------------
// tcgr_ram - generic simple dual-port RAM
// One write port, one read port with registered read data (read-old on
// a same-address collision).
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcgr_cursor.sv =====
// ----------------------------------------------------------------------------
// tcgr_cursor - cursor tracking and character decode
// Holds the cursor, maps the character to a glyph slot and builds the
// drawing command for the row sequencer.
// ----------------------------------------------------------------------------
module tcgr_cursor import tcgr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              put,        // put-character transaction this cycle
  input  logic [CODE_W-1:0] char_code,
  output cmd_t              cmd
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc, row_tmp;
  logic [CODE_W-1:0] slot;
  logic              scroll;

  // Glyph decode and base addresses from the current cursor
  always_comb begin
    slot         = glyph_slot(char_code);
    cmd.draw     = (char_code != CHAR_NEWLINE) && (slot != '0) &&
                   (32'(slot) < GLYPH_COUNT);
    cmd.scroll   = scroll;
    cmd.ram_base = STORE_AW'(32'(slot) * GLYPH_HEIGHT);
    cmd.pix_base = PIX_W'(32'(col_r) * CELL_WIDTH + 32'(row_r) * ROW_STRIDE);
  end

  // Cursor advance, wrap and clamp
  always_comb begin
    col_inc = {1'b0, col_r} + (COL_W+1)'(1);
    row_inc = {1'b0, row_r} + (ROW_W+1)'(1);
    if (char_code == CHAR_NEWLINE) begin
      col_nxt = '0;
      row_tmp = row_inc;
    end else if (32'(col_inc) >= COLUMNS) begin
      col_nxt = '0;
      row_tmp = row_inc;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_tmp = {1'b0, row_r};
    end
    scroll     = 32'(row_tmp) >= ROWS;
    row_nxt    = scroll ? ROW_W'(ROWS - 1) : row_tmp[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (put) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Checks
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor left the character grid");

  a_scroll_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    put && cmd.scroll |=> 32'(row_r) == ROWS - 1)
    else $error("scroll did not clamp the cursor to the last row");

endmodule

// ===== rtl/tcgr_seq.sv =====
// ----------------------------------------------------------------------------
// tcgr_seq - glyph row sequencer
// Steps through the glyph rows of a command, one font store read per
// cycle while the result channel does not stall, appends the scroll
// result and drives the registered result channel.
// ----------------------------------------------------------------------------
module tcgr_seq import tcgr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,        // new command taken this cycle
  input  cmd_t                cmd,
  input  logic [COLOR_W-1:0]  text_color,
  output logic                free,        // may take a new input transaction
  output logic                rd_en,
  output logic [STORE_AW-1:0] rd_addr,
  input  logic [FDATA_W-1:0]  rd_data,
  tcgr_out_if.source          out_ch
);

  // Issue stage
  logic [ROWCNT_W-1:0] a_rows_r;
  logic                a_scroll_r;
  logic [STORE_AW-1:0] a_raddr_r;
  logic [PIX_W-1:0]    a_pix_r;

  // Read-data stage
  logic                b_vld_r;
  logic                b_row_r;
  logic                b_last_r;
  logic [PIX_W-1:0]    b_pix_r;

  // Result register
  logic                o_vld_r;
  logic [PIX_W-1:0]    o_pix_r;
  logic [MASK_W-1:0]   o_mask_r;
  logic [COLOR_W-1:0]  o_color_r;
  logic                o_scroll_r;
  logic                o_last_r;

  logic o_adv, b_go, b_free, a_busy, issue, beat_row, beat_last;

  // Flow control
  always_comb begin
    o_adv     = !o_vld_r || out_ch.ready;
    b_go      = b_vld_r && o_adv;
    b_free    = !b_vld_r || o_adv;
    a_busy    = (a_rows_r != '0) || a_scroll_r;
    issue     = a_busy && b_free;
    beat_row  = a_rows_r != '0;
    beat_last = beat_row ? ((a_rows_r == ROWCNT_W'(1)) && !a_scroll_r) : 1'b1;
    free      = !a_busy || (issue && beat_last);
    rd_en     = issue && beat_row;
    rd_addr   = a_raddr_r;
  end

  // Issue stage: row count, font address and framebuffer address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r   <= '0;
      a_scroll_r <= 1'b0;
    end else if (load) begin
      a_rows_r   <= cmd.draw ? ROWCNT_W'(GLYPH_HEIGHT) : '0;
      a_scroll_r <= cmd.scroll;
    end else if (issue) begin
      if (beat_row) begin
        a_rows_r <= a_rows_r - ROWCNT_W'(1);
      end else begin
        a_scroll_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_raddr_r <= cmd.ram_base;
      a_pix_r   <= cmd.pix_base;
    end else if (issue && beat_row) begin
      a_raddr_r <= a_raddr_r + STORE_AW'(1);
      a_pix_r   <= a_pix_r + PIX_W'(LINE_PITCH);
    end
  end

  // Read-data stage: waits alongside the font store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (issue) begin
      b_vld_r <= 1'b1;
    end else if (b_go) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_row_r  <= beat_row;
      b_last_r <= beat_last;
      b_pix_r  <= beat_row ? a_pix_r : '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (b_go) begin
      o_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      o_pix_r    <= b_pix_r;
      o_mask_r   <= b_row_r ? rd_data[MASK_W-1:0] : '0;
      o_color_r  <= b_row_r ? text_color : '0;
      o_scroll_r <= !b_row_r;
      o_last_r   <= b_last_r;
    end
  end

  assign out_ch.valid         = o_vld_r;
  assign out_ch.pixel_address = o_pix_r;
  assign out_ch.pixel_mask    = o_mask_r;
  assign out_ch.color         = o_color_r;
  assign out_ch.scroll        = o_scroll_r;
  assign out_ch.last          = o_last_r;

  // Checks
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("command loaded while rows still pending");

  a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(a_rows_r) <= GLYPH_HEIGHT)
    else $error("glyph row count out of range");

  a_scroll_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_scroll_r |-> (o_pix_r == '0) && (o_mask_r == '0) &&
                              (o_color_r == '0) && o_last_r)
    else $error("scroll result carries drawing fields or is not last");

  a_final_row_drains: assert property (@(posedge clk) disable iff (!rst_n)
    issue && (a_rows_r == ROWCNT_W'(1)) && !load |=> a_rows_r == '0)
    else $error("row count did not reach zero after the final row");

endmodule

// ===== test/tb_text_console_glyph_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_glyph_renderer_unit - glyph renderer testbench
// Sends put-character and font-load transactions and keeps its own copy of
// the cursor, font store and text colour. Every framebuffer write and scroll
// request is checked field by field, in order. A directed table runs first,
// then random text in several colour phases.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_unit import tcgr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0]   addr;
    logic [MASK_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic               scroll;
    logic               last;
  } fb_write_t;

  typedef enum logic [1:0] {DO_PUT, DO_LOAD, DO_COLOR} step_kind_e;
  typedef enum logic [1:0] {BY_MODEL, NO_WRITES, SCROLL_ONLY, GLYPH_ROWS} outcome_e;

  // One table row; base/mask/color/scroll describe a listed glyph outcome
  typedef struct packed {
    step_kind_e         kind;
    logic [CODE_W-1:0]  code;
    logic [FADDR_W-1:0] faddr;
    logic [FDATA_W-1:0] fdata;
    logic [7:0]         reps;
    outcome_e           outcome;
    logic [PIX_W-1:0]   base;
    logic [MASK_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic               scroll;
  } step_t;

  // Slot of '!' is filled with 8'hFF and slot of 8'hFF with 8'h00 beforehand
  localparam step_t PLAN [0:23] = '{
    '{DO_PUT,   8'h21, 11'd0,    8'h00, 8'd1,  GLYPH_ROWS,  18'd0,      5'h1F, 15'h7FFF, 1'b0},
    '{DO_PUT,   8'hFF, 11'd0,    8'h00, 8'd1,  GLYPH_ROWS,  18'd5,      5'h00, 15'h7FFF, 1'b0},
    '{DO_PUT,   8'h20, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h00, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h80, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h9F, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h1F, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   CHAR_NEWLINE, 11'd0, 8'h00, 8'd1, NO_WRITES, 18'd0,     5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h21, 11'd0,    8'h00, 8'd1,  GLYPH_ROWS,  18'd5120,   5'h1F, 15'h7FFF, 1'b0},
    '{DO_LOAD,  8'h00, 11'h7FF,  8'hAA, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_LOAD,  8'h00, 11'd1920, 8'h55, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_LOAD,  8'h00, 11'd0,    8'hFF, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h7F, 11'd0,    8'h00, 8'd1,  BY_MODEL,    18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'hA0, 11'd0,    8'h00, 8'd1,  BY_MODEL,    18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h7E, 11'd0,    8'h00, 8'd1,  BY_MODEL,    18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   CHAR_NEWLINE, 11'd0, 8'h00, 8'd25, NO_WRITES, 18'd0,    5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   CHAR_NEWLINE, 11'd0, 8'h00, 8'd1, SCROLL_ONLY, 18'd0,   5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h20, 11'd0,    8'h00, 8'd95, NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'h21, 11'd0,    8'h00, 8'd1,  GLYPH_ROWS,  18'd133595, 5'h1F, 15'h7FFF, 1'b1},
    '{DO_COLOR, 8'h00, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0},
    '{DO_PUT,   8'hFF, 11'd0,    8'h00, 8'd1,  GLYPH_ROWS,  18'd133120, 5'h00, 15'h0000, 1'b0},
    '{DO_COLOR, 8'h00, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h7FFF, 1'b0},
    '{DO_PUT,   8'h21, 11'd0,    8'h00, 8'd1,  GLYPH_ROWS,  18'd133125, 5'h1F, 15'h7FFF, 1'b0},
    '{DO_PUT,   8'h1E, 11'd0,    8'h00, 8'd1,  NO_WRITES,   18'd0,      5'h00, 15'h0000, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [COLOR_W-1:0] cfg_wdata;

  tcgr_in_if  in_ch ();
  tcgr_out_if out_ch ();

  text_console_glyph_renderer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Console state as the block should hold it
  logic [FDATA_W-1:0] font_mem   [STORE_DEPTH];
  bit                 font_known [STORE_DEPTH];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] ink;

  fb_write_t fb_writes_due [$];
  fb_write_t fresh_writes  [$];
  fb_write_t listed_writes [$];

  int          mismatches;
  int unsigned stall_left;
  bit          calm;

  always #5ns clk = ~clk;

  // Give up long after the slowest legal run would have finished
  initial begin
    #5ms;
    $display("FAIL text_console_glyph_renderer_unit");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 64) $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int glyph_index(input logic [CODE_W-1:0] code);
    if (code >= CHAR_LATIN_LO) return int'(code) - int'(LATIN_OFFSET);
    if (code >= CHAR_HIGH_CTRL || code < CHAR_PRINT_LO) return 0;
    return int'(code) - int'(CHAR_PRINT_LO);
  endfunction

  // Apply one accepted transaction; the writes it causes land in fresh_writes
  function automatic void advance_console(input logic op, input logic [CODE_W-1:0] code,
                                          input logic [FADDR_W-1:0] faddr,
                                          input logic [FDATA_W-1:0] fdata);
    int        slot;
    int        base;
    fb_write_t w;
    fresh_writes.delete();
    if (op == OP_LOAD) begin
      if (faddr < STORE_DEPTH) begin
        font_mem[faddr]   = fdata;
        font_known[faddr] = 1'b1;
      end
      return;
    end
    if (code == CHAR_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else begin
      slot = glyph_index(code);
      if (slot != 0 && slot < GLYPH_COUNT) begin
        base = cur_col * CELL_WIDTH + cur_row * GLYPH_HEIGHT * LINE_PITCH;
        for (int y = 0; y < GLYPH_HEIGHT; y++) begin
          w.addr   = PIX_W'(base + y * LINE_PITCH);
          w.mask   = font_mem[slot * GLYPH_HEIGHT + y][MASK_W-1:0];
          w.color  = ink;
          w.scroll = 1'b0;
          w.last   = 1'b0;
          fresh_writes.push_back(w);
        end
      end
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    // past the bottom line: clamp and ask for a scroll
    if (cur_row >= ROWS) begin
      cur_row  = ROWS - 1;
      w        = '0;
      w.scroll = 1'b1;
      fresh_writes.push_back(w);
    end
    if (fresh_writes.size() != 0) begin
      w      = fresh_writes[fresh_writes.size() - 1];
      w.last = 1'b1;
      fresh_writes[fresh_writes.size() - 1] = w;
    end
  endfunction

  // Expand a table row's listed outcome into writes
  function automatic void spell_out(input step_t s);
    fb_write_t w;
    listed_writes.delete();
    if (s.outcome == GLYPH_ROWS) begin
      for (int y = 0; y < GLYPH_HEIGHT; y++) begin
        w = '{PIX_W'(s.base + y * LINE_PITCH), s.mask, s.color, 1'b0, 1'b0};
        listed_writes.push_back(w);
      end
    end
    if (s.outcome == SCROLL_ONLY || (s.outcome == GLYPH_ROWS && s.scroll)) begin
      w        = '0;
      w.scroll = 1'b1;
      listed_writes.push_back(w);
    end
    if (listed_writes.size() != 0) begin
      w      = listed_writes[listed_writes.size() - 1];
      w.last = 1'b1;
      listed_writes[listed_writes.size() - 1] = w;
    end
  endfunction

  // Send one transaction, optionally after an idle burst
  task automatic issue(input logic op, input logic [CODE_W-1:0] code,
                       input logic [FADDR_W-1:0] faddr, input logic [FDATA_W-1:0] fdata,
                       input bit listed);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.char_code    <= code;
    in_ch.font_address <= faddr;
    in_ch.font_data    <= fdata;
    do @(posedge clk); while (!in_ch.ready);
    advance_console(op, code, faddr, fdata);
    if (listed) begin
      foreach (listed_writes[i]) fb_writes_due.push_back(listed_writes[i]);
    end else begin
      foreach (fresh_writes[i]) fb_writes_due.push_back(fresh_writes[i]);
    end
  endtask

  // Load a glyph's rows: all with a fixed byte, or only missing ones at random
  task automatic stock_glyph(input int slot, input bit fixed, input logic [FDATA_W-1:0] data);
    int row_addr;
    for (int y = 0; y < GLYPH_HEIGHT; y++) begin
      row_addr = slot * GLYPH_HEIGHT + y;
      if (fixed || !font_known[row_addr])
        issue(OP_LOAD, CODE_W'($urandom), FADDR_W'(row_addr),
              fixed ? data : FDATA_W'($urandom), 1'b0);
    end
  endtask

  // Print a character, making sure its glyph has been loaded first
  task automatic put_char(input logic [CODE_W-1:0] code, input bit listed);
    int slot;
    slot = glyph_index(code);
    if (slot != 0 && slot < GLYPH_COUNT) stock_glyph(slot, 1'b0, '0);
    issue(OP_PUT, code, FADDR_W'($urandom), FDATA_W'($urandom), listed);
  endtask

  // Hold off until every write has come back and the block has gone quiet
  task automatic drain_console();
    in_ch.valid <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_ink(input logic [COLOR_W-1:0] shade);
    drain_console();
    cfg_we    <= 1'b1;
    cfg_wdata <= shade;
    @(posedge clk);
    cfg_we <= 1'b0;
    ink = shade;
  endtask

  // Result side ready with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expected write
  always @(posedge clk) begin
    fb_write_t got;
    fb_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pixel_address, out_ch.pixel_mask, out_ch.color,
              out_ch.scroll, out_ch.last};
      if (fb_writes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result addr %0h scroll %0b", got.addr, got.scroll));
      end else begin
        want = fb_writes_due.pop_front();
        if (got.addr !== want.addr)
          flag_mismatch($sformatf("pixel_address %0h, expected %0h", got.addr, want.addr));
        if (got.mask !== want.mask)
          flag_mismatch($sformatf("pixel_mask %0h, expected %0h", got.mask, want.mask));
        if (got.color !== want.color)
          flag_mismatch($sformatf("color %0h, expected %0h", got.color, want.color));
        if (got.scroll !== want.scroll)
          flag_mismatch($sformatf("scroll %0b, expected %0b", got.scroll, want.scroll));
        if (got.last !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  // Stimulus
  initial begin
    step_t              s;
    logic [COLOR_W-1:0] shade;
    logic [CODE_W-1:0]  code;
    int                 roll;
    int                 pick;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_PUT;
    in_ch.char_code    <= '0;
    in_ch.font_address <= '0;
    in_ch.font_data    <= '0;
    cur_col    = 0;
    cur_row    = 0;
    ink        = COLOR_RESET;
    mismatches = 0;
    calm       = 1'b0;
    foreach (font_known[i]) font_known[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // known glyphs for the listed outcomes: full rows and empty rows
    stock_glyph(glyph_index(8'h21), 1'b1, 8'hFF);
    stock_glyph(glyph_index(8'hFF), 1'b1, 8'h00);

    foreach (PLAN[i]) begin
      s = PLAN[i];
      if (s.kind == DO_COLOR) begin
        set_ink(s.color);
      end else begin
        spell_out(s);
        repeat (s.reps) begin
          if (s.kind == DO_LOAD)
            issue(OP_LOAD, CODE_W'($urandom), s.faddr, s.fdata, s.outcome != BY_MODEL);
          else
            put_char(s.code, s.outcome != BY_MODEL);
        end
      end
    end

    // Random text in colour phases; the last phase runs without idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: shade = COLOR_W'($urandom);
        1: shade = '0;
        2: shade = COLOR_W'($urandom);
        default: shade = COLOR_RESET;
      endcase
      calm = (phase == 3);
      set_ink(shade);
      repeat (10) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          issue(OP_LOAD, CODE_W'($urandom), FADDR_W'($urandom), FDATA_W'($urandom), 1'b0);
        end else if (roll < 22) begin
          put_char(CHAR_NEWLINE, 1'b0);
        end else begin
          // mostly a small working set so glyphs get reused, sometimes anything
          if ($urandom_range(0, 2) == 0) begin
            code = CODE_W'($urandom);
          end else begin
            pick = $urandom_range(0, 15);
            code = (pick < 8) ? 8'h41 + CODE_W'(pick) : 8'hD8 + CODE_W'(pick);
          end
          put_char(code, 1'b0);
        end
      end
    end

    drain_console();
    if (mismatches == 0) begin
      $display("PASS text_console_glyph_renderer_unit");
    end else begin
      $display("FAIL text_console_glyph_renderer_unit");
    end
    $finish;
  end

endmodule
